// ===== src/lzw_pkg.sv =====
// Package: shared constants, payload types and hash for the LZW byte encoder.
`default_nettype none
package lzw_pkg;

  localparam int CODE_LIMIT      = 4095;
  localparam int FIRST_FREE_CODE = 257;
  localparam int CODE_W          = 12;
  localparam int NFC_W           = 13;
  localparam int SLOT_W          = 13;
  localparam int DICT_DEPTH      = 1 << CODE_W;
  localparam int HASH_DEPTH      = 1 << SLOT_W;
  localparam int DICT_W          = SLOT_W + CODE_W + 8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_code;
    logic              run_last;
    logic              message_end;
  } out_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] prefix;
    logic [7:0]        suffix;
  } dict_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HWAIT = 4'b0010,
    ST_DWAIT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  function automatic logic [SLOT_W-1:0] key_hash(input logic [CODE_W-1:0] prefix,
                                                 input logic [7:0] b);
    key_hash = {b, 5'b0} ^ {1'b0, prefix};
  endfunction

endpackage
`default_nettype wire

// ===== src/lzw_byte_encoder_top.sv =====
// Top level: LZW encoder with hashed dictionary lookup and a two-beat output queue.
//
//  channel | direction | payload | handshake
//  in      | input     | in_t    | in_valid / in_stall
//  out     | output    | out_t   | out_valid / out_stall
//
// A byte that opens a message is done at accept; if it is also the last, it then
// passes through the emit state. Otherwise: accept, then per hash probe a hash
// memory read plus a dictionary memory read when the slot holds a live code, then
// an emit step when it emits codes; linear probing sets the probe count, usually 1.
// Reset clears control state only; both memories need no clearing.
// The output queue holds two beats; emission waits while it lacks room.
`default_nettype none
module lzw_byte_encoder_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lzw_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lzw_pkg::out_t      out_data
);

  lzw_pkg::state_t                  state;
  logic [lzw_pkg::CODE_W-1:0]       pending;
  logic [lzw_pkg::CODE_W-1:0]       pend_new;
  logic [lzw_pkg::NFC_W-1:0]        nfc;
  logic                             mid;
  logic [7:0]                       cur_byte;
  logic                             cur_last;
  logic [lzw_pkg::SLOT_W-1:0]       slot;
  logic [lzw_pkg::CODE_W-1:0]       cand;
  lzw_pkg::out_t                    res0, res1;
  logic                             two;
  logic                             do_ins;
  logic                             end_msg;
  lzw_pkg::out_t                    q0, q1;
  logic [1:0]                       qcnt;
  lzw_pkg::out_t                    q0_next, q1_next;
  logic [1:0]                       qcnt_next;

  logic [lzw_pkg::SLOT_W-1:0]       hash_raddr;
  logic [lzw_pkg::CODE_W-1:0]       hash_rdata;
  logic [lzw_pkg::DICT_W-1:0]       dict_raw;
  lzw_pkg::dict_t                   dict_rd;
  lzw_pkg::dict_t                   dict_wd;
  logic                             ins_we;
  logic                             accept, pop, room, live_code, push;
  logic [1:0]                       cnt_a;
  lzw_pkg::out_t                    qa0, qa1;

  assign in_stall  = (state != lzw_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (qcnt != 2'd0);
  assign out_data  = q0;
  assign pop       = out_valid && !out_stall;
  assign room      = two ? (qcnt == 2'd0) : (qcnt != 2'd2);
  assign push      = (state == lzw_pkg::ST_EMIT) && room;
  assign dict_rd   = lzw_pkg::dict_t'(dict_raw);

  // Probe the next slot straight from the compare cycle.
  assign hash_raddr = (state == lzw_pkg::ST_DWAIT) ? slot + 1'b1
                    : lzw_pkg::key_hash(pending, in_data.in_byte);

  assign live_code = (hash_rdata >= lzw_pkg::CODE_W'(lzw_pkg::FIRST_FREE_CODE))
                  && ({1'b0, hash_rdata} < nfc);

  assign ins_we  = (state == lzw_pkg::ST_EMIT) && room && do_ins
                && (nfc <= lzw_pkg::NFC_W'(lzw_pkg::CODE_LIMIT));
  assign dict_wd = '{slot: slot, prefix: pending, suffix: cur_byte};

  lzw_ram #(.WIDTH(lzw_pkg::CODE_W), .DEPTH(lzw_pkg::HASH_DEPTH)) u_hash (
    .clk   (clk),
    .we    (ins_we),
    .waddr (slot),
    .wdata (nfc[lzw_pkg::CODE_W-1:0]),
    .raddr (hash_raddr),
    .rdata (hash_rdata)
  );

  lzw_ram #(.WIDTH(lzw_pkg::DICT_W), .DEPTH(lzw_pkg::DICT_DEPTH)) u_dict (
    .clk   (clk),
    .we    (ins_we),
    .waddr (nfc[lzw_pkg::CODE_W-1:0]),
    .wdata (dict_wd),
    .raddr (hash_rdata),
    .rdata (dict_raw)
  );

  // Queue contents after this cycle's pop, then after this cycle's push.
  always_comb begin
    qa0   = q0;
    qa1   = q1;
    cnt_a = qcnt;
    if (pop) begin
      qa0   = q1;
      cnt_a = qcnt - 2'd1;
    end
    q0_next   = qa0;
    q1_next   = qa1;
    qcnt_next = cnt_a;
    if (push) begin
      if (cnt_a == 2'd0) begin
        q0_next = res0;
        if (two) begin
          q1_next = res1;
        end
      end else begin
        q1_next = res0;
      end
      qcnt_next = cnt_a + (two ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lzw_pkg::ST_IDLE;
      pending <= '0;
      nfc     <= lzw_pkg::NFC_W'(lzw_pkg::FIRST_FREE_CODE);
      mid     <= 1'b0;
      qcnt    <= 2'd0;
    end else begin
      q0   <= q0_next;
      q1   <= q1_next;
      qcnt <= qcnt_next;
      case (state)
        lzw_pkg::ST_IDLE: begin
          if (accept) begin
            cur_byte <= in_data.in_byte;
            cur_last <= in_data.in_last;
            slot     <= hash_raddr;
            if (!mid) begin
              if (in_data.in_last) begin
                res0    <= '{out_code: {4'b0, in_data.in_byte}, run_last: 1'b1,
                             message_end: 1'b1};
                two     <= 1'b0;
                do_ins  <= 1'b0;
                end_msg <= 1'b1;
                state   <= lzw_pkg::ST_EMIT;
              end else begin
                pending <= {4'b0, in_data.in_byte};
                mid     <= 1'b1;
              end
            end else begin
              state <= lzw_pkg::ST_HWAIT;
            end
          end
        end
        lzw_pkg::ST_HWAIT: begin
          if (live_code) begin
            cand  <= hash_rdata;
            state <= lzw_pkg::ST_DWAIT;
          end else begin
            res0     <= '{out_code: pending, run_last: !cur_last, message_end: 1'b0};
            res1     <= '{out_code: {4'b0, cur_byte}, run_last: 1'b1, message_end: 1'b1};
            two      <= cur_last;
            do_ins   <= 1'b1;
            end_msg  <= cur_last;
            pend_new <= {4'b0, cur_byte};
            state    <= lzw_pkg::ST_EMIT;
          end
        end
        lzw_pkg::ST_DWAIT: begin
          if (dict_rd.slot != slot) begin
            // Slot not owned by its code: free, so the key is absent.
            res0     <= '{out_code: pending, run_last: !cur_last, message_end: 1'b0};
            res1     <= '{out_code: {4'b0, cur_byte}, run_last: 1'b1, message_end: 1'b1};
            two      <= cur_last;
            do_ins   <= 1'b1;
            end_msg  <= cur_last;
            pend_new <= {4'b0, cur_byte};
            state    <= lzw_pkg::ST_EMIT;
          end else if (dict_rd.prefix == pending && dict_rd.suffix == cur_byte) begin
            if (cur_last) begin
              res0    <= '{out_code: cand, run_last: 1'b1, message_end: 1'b1};
              two     <= 1'b0;
              do_ins  <= 1'b0;
              end_msg <= 1'b1;
              state   <= lzw_pkg::ST_EMIT;
            end else begin
              pending <= cand;
              state   <= lzw_pkg::ST_IDLE;
            end
          end else begin
            slot  <= slot + 1'b1;
            state <= lzw_pkg::ST_HWAIT;
          end
        end
        lzw_pkg::ST_EMIT: begin
          if (room) begin
            if (end_msg) begin
              nfc     <= lzw_pkg::NFC_W'(lzw_pkg::FIRST_FREE_CODE);
              mid     <= 1'b0;
              pending <= '0;
            end else begin
              if (ins_we) begin
                nfc <= nfc + 1'b1;
              end
              pending <= pend_new;
            end
            state <= lzw_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= lzw_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_qcnt: assert property (@(posedge clk) disable iff (rst) qcnt != 2'd3)
    else $error("output queue overflow");
  a_nfc: assert property (@(posedge clk) disable iff (rst)
    nfc >= lzw_pkg::NFC_W'(lzw_pkg::FIRST_FREE_CODE)
    && nfc <= lzw_pkg::NFC_W'(lzw_pkg::CODE_LIMIT + 1))
    else $error("free code out of range");
  a_dwait: assert property (@(posedge clk) disable iff (rst)
    state == lzw_pkg::ST_DWAIT |-> $past(state) == lzw_pkg::ST_HWAIT)
    else $error("dictionary compare without hash read");
  a_ins: assert property (@(posedge clk) disable iff (rst)
    ins_we |=> state == lzw_pkg::ST_IDLE && out_valid)
    else $error("insert without emitted code");

endmodule
`default_nettype wire

// ===== src/lzw_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
